### src/tmsd_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the triangle midpoint subdivider.
package tmsd_pkg;

  localparam int COORD_W = 32;
  localparam int SIZE_W  = 31;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 31'd65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;
  typedef logic [SIZE_W-1:0] size_val_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_SIZE_X = 2'd1,
    CFG_SIZE_Y = 2'd2,
    CFG_SIZE_Z = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN     = 2'd0,
    MODE_ELLIPSOID = 2'd1,
    MODE_ELLIPSE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    MID_AB = 2'd0,
    MID_BC = 2'd1,
    MID_AC = 2'd2
  } mid_sel_e;

  typedef enum logic [1:0] {
    PH_T0 = 2'd0,
    PH_T1 = 2'd1,
    PH_T2 = 2'd2,
    PH_T3 = 2'd3
  } em_ph_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    size_val_t         size_x;
    size_val_t         size_y;
    size_val_t         size_z;
  } cfg_t;

  typedef struct packed {
    mid_sel_e idx;
    vec_t     m;
    vec_t     cor;
  } mid_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } tri_in_t;

  typedef struct packed {
    coord_t out_a_x;
    coord_t out_a_y;
    coord_t out_a_z;
    coord_t out_b_x;
    coord_t out_b_y;
    coord_t out_b_z;
    coord_t out_c_x;
    coord_t out_c_y;
    coord_t out_c_z;
    logic   last;
  } tri_out_t;

endpackage

### src/tmsd_norm.sv
`timescale 1ns / 1ps
// Midpoint projection pipeline: squares, integer square root, division and scaling.
module tmsd_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tmsd_pkg::cfg_t cfg,
  input  logic           in_vld,
  input  tmsd_pkg::mid_t in_elem,
  output logic           out_vld,
  output tmsd_pkg::mid_t out_elem
);
  import tmsd_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int QW = FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;
  localparam int PW = UW + 32;
  localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

  function automatic logic [31:0] mag32(coord_t v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  logic        s1_vld_r;
  mid_t        s1_elem_r;
  logic [63:0] s1_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_elem_r <= in_elem;
    for (int i = 0; i < 3; i++) begin
      s1_sq_r[i] <= {32'd0, mag32(in_elem.m[i])} * {32'd0, mag32(in_elem.m[i])};
    end
  end

  logic        sq_vld_r  [0:SQ_STEPS];
  mid_t        sq_elem_r [0:SQ_STEPS];
  logic [63:0] sq_n_r    [0:SQ_STEPS];
  logic [63:0] sq_r_r    [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_elem_r[0] <= s1_elem_r;
    sq_n_r[0]    <= s1_sq_r[0] + s1_sq_r[1] + ((cfg.mode == MODE_ELLIPSOID) ? s1_sq_r[2] : 64'd0);
    sq_r_r[0]    <= 64'd0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [64:0] trial;
    logic        fits;

    assign trial = {1'b0, sq_r_r[k]} + {1'b0, BIT};
    assign fits  = {1'b0, sq_n_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_elem_r[k+1] <= sq_elem_r[k];
      sq_n_r[k+1]    <= fits ? sq_n_r[k] - trial[63:0] : sq_n_r[k];
      sq_r_r[k+1]    <= fits ? (sq_r_r[k] >> 1) + BIT : (sq_r_r[k] >> 1);
    end
  end

  logic          dv_vld_r  [1:QW];
  mid_t          dv_elem_r [1:QW];
  logic [31:0]   dv_len_r  [1:QW];
  logic [32:0]   dv_rem_r  [1:QW][3];
  logic [QW-1:0] dv_q_r    [1:QW][3];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic          st_vld;
    mid_t          st_elem;
    logic [31:0]   st_len;
    logic [32:0]   st_rin [3];
    logic [QW-1:0] st_qin [3];
    logic [32:0]   rem_nxt [3];
    logic [QW-1:0] q_nxt [3];

    if (j == 0) begin : g_first
      always_comb begin
        st_vld  = sq_vld_r[SQ_STEPS];
        st_elem = sq_elem_r[SQ_STEPS];
        st_len  = sq_r_r[SQ_STEPS][31:0];
        for (int i = 0; i < 3; i++) begin
          st_rin[i] = {1'b0, mag32(sq_elem_r[SQ_STEPS].m[i])};
          st_qin[i] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        st_vld  = dv_vld_r[j];
        st_elem = dv_elem_r[j];
        st_len  = dv_len_r[j];
        for (int i = 0; i < 3; i++) begin
          st_rin[i] = {dv_rem_r[j][i][31:0], 1'b0};
          st_qin[i] = dv_q_r[j][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (st_rin[i] >= {1'b0, st_len}) begin
          rem_nxt[i] = st_rin[i] - {1'b0, st_len};
          q_nxt[i]   = {st_qin[i][QW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = st_rin[i];
          q_nxt[i]   = {st_qin[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= st_vld;
      end
    end

    always_ff @(posedge clk) begin
      dv_elem_r[j+1] <= st_elem;
      dv_len_r[j+1]  <= st_len;
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[j+1][i] <= rem_nxt[i];
        dv_q_r[j+1][i]   <= q_nxt[i];
      end
    end
  end

  logic                 mu_vld_r;
  mid_t                 mu_elem_r;
  logic signed [PW-1:0] mu_prod_r [3];
  logic signed [PW-1:0] mu_prod_nxt [3];
  logic signed [UW-1:0] unit_v [3];
  size_val_t            size_v [3];

  assign size_v[0] = cfg.size_x;
  assign size_v[1] = cfg.size_y;
  assign size_v[2] = cfg.size_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_len_r[QW] == 32'd0) begin
        unit_v[i] = '0;
      end else if (dv_elem_r[QW].m[i][31]) begin
        unit_v[i] = UW'(0) - {1'b0, dv_q_r[QW][i]};
      end else begin
        unit_v[i] = {1'b0, dv_q_r[QW][i]};
      end
      mu_prod_nxt[i] = PW'(unit_v[i]) * PW'($signed({1'b0, size_v[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else begin
      mu_vld_r <= dv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    mu_elem_r <= dv_elem_r[QW];
    for (int i = 0; i < 3; i++) begin
      mu_prod_r[i] <= mu_prod_nxt[i];
    end
  end

  logic                 fo_vld_r;
  mid_t                 fo_elem_r;
  mid_t                 fo_elem_nxt;
  logic signed [PW-1:0] shv [3];
  coord_t               proj [3];

  always_comb begin
    fo_elem_nxt = mu_elem_r;
    for (int i = 0; i < 3; i++) begin
      shv[i] = (cfg.mode == MODE_ELLIPSE) ? (mu_prod_r[i] >>> (FRAC_BITS + 1))
                                         : (mu_prod_r[i] >>> FRAC_BITS);
      if (shv[i] > SAT_MAX) begin
        proj[i] = 32'h7FFF_FFFF;
      end else if (shv[i] < SAT_MIN) begin
        proj[i] = 32'h8000_0000;
      end else begin
        proj[i] = shv[i][31:0];
      end
      if (cfg.mode == MODE_ELLIPSOID || (cfg.mode == MODE_ELLIPSE && i < 2)) begin
        fo_elem_nxt.m[i] = proj[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fo_vld_r <= 1'b0;
    end else begin
      fo_vld_r <= mu_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fo_elem_r <= fo_elem_nxt;
  end

  assign out_vld  = fo_vld_r;
  assign out_elem = fo_elem_r;

endmodule

### src/triangle_midpoint_subdivider.sv
`timescale 1ns / 1ps
// Top level of the triangle midpoint subdivider.
// A triangle is taken when start is high and busy low; busy then stays high until the
// midpoints of all its edges are issued and no new triangle is taken meanwhile. They go
// one per cycle through a shared projection pipeline (square root one bit a stage,
// division one quotient bit a stage), and the four sub-triangles come out on
// consecutive cycles, out_valid high on each. Results cannot be held off: the receiver
// must take them as shown.
module triangle_midpoint_subdivider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  tmsd_pkg::tri_in_t                     in_data,
  output logic                                  out_valid,
  output tmsd_pkg::tri_out_t                    out_data,
  input  logic                                  cfg_we,
  input  logic [tmsd_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [tmsd_pkg::CFG_W-1:0]            cfg_data
);
  import tmsd_pkg::*;

  function automatic coord_t midp(coord_t p, coord_t q);
    logic [32:0] s;
    s = {p[31], p} + {q[31], q};
    return s[32:1];
  endfunction

  function automatic tri_out_t mk_tri(vec_t p, vec_t q, vec_t r, logic lst);
    tri_out_t t;
    t.out_a_x = p[0];
    t.out_a_y = p[1];
    t.out_a_z = p[2];
    t.out_b_x = q[0];
    t.out_b_y = q[1];
    t.out_b_z = q[2];
    t.out_c_x = r[0];
    t.out_c_y = r[1];
    t.out_c_z = r[2];
    t.last    = lst;
    return t;
  endfunction

  logic [MODE_W-1:0] mode_r;
  size_val_t         size_x_r;
  size_val_t         size_y_r;
  size_val_t         size_z_r;
  cfg_t              cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      size_x_r <= SIZE_RST;
      size_y_r <= SIZE_RST;
      size_z_r <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_idx))
        CFG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        CFG_SIZE_Z: size_z_r <= cfg_data;
      endcase
    end
  end

  assign cfg.mode   = mode_r;
  assign cfg.size_x = size_x_r;
  assign cfg.size_y = size_y_r;
  assign cfg.size_z = size_z_r;

  logic     accept;
  logic     fd_act_r;
  mid_sel_e fd_sel_r;
  vec_t     fd_a_r, fd_b_r, fd_c_r, fd_ab_r, fd_bc_r, fd_ac_r;
  vec_t     in_a, in_b, in_c;
  logic     nm_in_vld;
  mid_t     nm_in_elem;

  assign busy   = fd_act_r;
  assign accept = start && !busy;

  assign in_a = {in_data.a_z, in_data.a_y, in_data.a_x};
  assign in_b = {in_data.b_z, in_data.b_y, in_data.b_x};
  assign in_c = {in_data.c_z, in_data.c_y, in_data.c_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_act_r <= 1'b0;
      fd_sel_r <= MID_AB;
    end else if (accept) begin
      fd_act_r <= 1'b1;
      fd_sel_r <= MID_AB;
    end else if (fd_act_r) begin
      case (fd_sel_r)
        MID_AB:  fd_sel_r <= MID_BC;
        MID_BC:  fd_sel_r <= MID_AC;
        default: fd_sel_r <= MID_AB;
      endcase
      if (fd_sel_r == MID_AC) begin
        fd_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fd_a_r <= in_a;
      fd_b_r <= in_b;
      fd_c_r <= in_c;
      for (int i = 0; i < 3; i++) begin
        fd_ab_r[i] <= midp(in_a[i], in_b[i]);
        fd_bc_r[i] <= midp(in_b[i], in_c[i]);
        fd_ac_r[i] <= midp(in_a[i], in_c[i]);
      end
    end
  end

  always_comb begin
    nm_in_vld      = fd_act_r;
    nm_in_elem.idx = fd_sel_r;
    case (fd_sel_r)
      MID_AB: begin
        nm_in_elem.m   = fd_ab_r;
        nm_in_elem.cor = fd_a_r;
      end
      MID_BC: begin
        nm_in_elem.m   = fd_bc_r;
        nm_in_elem.cor = fd_b_r;
      end
      default: begin
        nm_in_elem.m   = fd_ac_r;
        nm_in_elem.cor = fd_c_r;
      end
    endcase
  end

  logic nm_vld;
  mid_t nm_elem;

  tmsd_norm #(
    .FRAC_BITS(FRAC_BITS)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_vld   (nm_in_vld),
    .in_elem  (nm_in_elem),
    .out_vld  (nm_vld),
    .out_elem (nm_elem)
  );

  vec_t col_a_r, col_b_r, col_ab_r, col_bc_r;

  always_ff @(posedge clk) begin
    if (nm_vld) begin
      case (nm_elem.idx)
        MID_AB: begin
          col_ab_r <= nm_elem.m;
          col_a_r  <= nm_elem.cor;
        end
        MID_BC: begin
          col_bc_r <= nm_elem.m;
          col_b_r  <= nm_elem.cor;
        end
        default: begin
        end
      endcase
    end
  end

  logic     launch;
  logic     em_act_r;
  em_ph_e   em_ph_r;
  vec_t     em_b_r, em_c_r, em_ab_r, em_bc_r, em_ac_r;
  logic     out_valid_r;
  tri_out_t out_data_r;

  assign launch = nm_vld && (nm_elem.idx == MID_AC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_act_r    <= 1'b0;
      em_ph_r     <= PH_T0;
      out_valid_r <= 1'b0;
    end else if (launch) begin
      em_act_r    <= 1'b1;
      em_ph_r     <= PH_T1;
      out_valid_r <= 1'b1;
    end else if (em_act_r) begin
      em_ph_r     <= em_ph_e'(em_ph_r + 2'd1);
      out_valid_r <= 1'b1;
      if (em_ph_r == PH_T3) begin
        em_act_r <= 1'b0;
      end
    end else begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      em_b_r     <= col_b_r;
      em_c_r     <= nm_elem.cor;
      em_ab_r    <= col_ab_r;
      em_bc_r    <= col_bc_r;
      em_ac_r    <= nm_elem.m;
      out_data_r <= mk_tri(col_a_r, col_ab_r, nm_elem.m, 1'b0);
    end else if (em_act_r) begin
      case (em_ph_r)
        PH_T1:   out_data_r <= mk_tri(em_ab_r, em_b_r, em_bc_r, 1'b0);
        PH_T2:   out_data_r <= mk_tri(em_ab_r, em_bc_r, em_ac_r, 1'b0);
        default: out_data_r <= mk_tri(em_ac_r, em_bc_r, em_c_r, 1'b1);
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/tmsd_chk.sv
`timescale 1ns / 1ps
// Port checker for the triangle midpoint subdivider, with its bind.
module tmsd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input tmsd_pkg::tri_out_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy ##1 busy ##1 busy ##1 !busy)
    else $error("busy window after a transaction is wrong");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("result burst broken before last");

  a_last_closes_four: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> $past(out_valid, 1) && $past(out_valid, 2) &&
      $past(out_valid, 3) && !$past(out_data.last, 1))
    else $error("last not preceded by three results");

  a_no_idle_results: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> !out_data.last)
    else $error("burst opened with last set");

endmodule

bind triangle_midpoint_subdivider tmsd_chk u_tmsd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### dv/triangle_midpoint_subdivider_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle midpoint subdivider.
module triangle_midpoint_subdivider_tb;
  import tmsd_pkg::*;

  localparam int FRAC = 16;
  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
  localparam int WDOG_LIMIT = 3000;
  localparam int N_RAND = 350;

  typedef struct {
    logic [MODE_W-1:0] mode;
    tri_in_t           corners;
    bit                typed;
    longint            ab [3];
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  tri_in_t   in_data;
  logic      out_valid;
  tri_out_t  out_data;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  logic [MODE_W-1:0] cur_mode;
  longint unsigned   cur_size [3];
  tri_out_t          subtri_q [$];
  int                n_err;
  int                idle_cycles;
  dir_row_t          dir_rows [$];

  triangle_midpoint_subdivider #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic longint unit_comp(longint m, longint unsigned len);
    longint unsigned mag, q;
    if (len == 0) return 0;
    mag = (m < 0) ? -m : m;
    q = (mag << FRAC) / len;
    return (m < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scaled_axis(longint u, longint unsigned sz, int s);
    longint p;
    p = (u * longint'(sz)) >>> s;
    if (p > 64'sd2147483647) return 64'sd2147483647;
    if (p < -64'sd2147483648) return -64'sd2147483648;
    return p;
  endfunction

  function automatic void edge_midpoint(input longint p [3], input longint q [3],
                                        output longint r [3]);
    longint unsigned len;
    longint u [3];
    for (int i = 0; i < 3; i++) r[i] = (p[i] + q[i]) >>> 1;
    if (cur_mode == MODE_ELLIPSOID) begin
      len = int_sqrt(sq_mag(r[0]) + sq_mag(r[1]) + sq_mag(r[2]));
      for (int i = 0; i < 3; i++) u[i] = unit_comp(r[i], len);
      for (int i = 0; i < 3; i++) r[i] = scaled_axis(u[i], cur_size[i], FRAC);
    end else if (cur_mode == MODE_ELLIPSE) begin
      len = int_sqrt(sq_mag(r[0]) + sq_mag(r[1]));
      for (int i = 0; i < 2; i++) u[i] = unit_comp(r[i], len);
      for (int i = 0; i < 2; i++) r[i] = scaled_axis(u[i], cur_size[i], FRAC + 1);
    end
  endfunction

  function automatic tri_out_t make_subtri(longint p [3], longint q [3], longint r [3],
                                           bit lst);
    tri_out_t t;
    t.out_a_x = coord_t'(p[0]); t.out_a_y = coord_t'(p[1]); t.out_a_z = coord_t'(p[2]);
    t.out_b_x = coord_t'(q[0]); t.out_b_y = coord_t'(q[1]); t.out_b_z = coord_t'(q[2]);
    t.out_c_x = coord_t'(r[0]); t.out_c_y = coord_t'(r[1]); t.out_c_z = coord_t'(r[2]);
    t.last = lst;
    return t;
  endfunction

  // typed_ab overrides the computed ab midpoint where a row gives it by hand
  function automatic void predict_subtris(tri_in_t t, bit typed, longint typed_ab [3]);
    longint a [3], b [3], c [3], ab [3], bc [3], ac [3];
    a = '{longint'(t.a_x), longint'(t.a_y), longint'(t.a_z)};
    b = '{longint'(t.b_x), longint'(t.b_y), longint'(t.b_z)};
    c = '{longint'(t.c_x), longint'(t.c_y), longint'(t.c_z)};
    edge_midpoint(a, b, ab);
    edge_midpoint(b, c, bc);
    edge_midpoint(a, c, ac);
    if (typed) ab = typed_ab;
    subtri_q.push_back(make_subtri(a, ab, ac, 1'b0));
    subtri_q.push_back(make_subtri(ab, b, bc, 1'b0));
    subtri_q.push_back(make_subtri(ab, bc, ac, 1'b0));
    subtri_q.push_back(make_subtri(ac, bc, c, 1'b1));
  endfunction

  task automatic report_mismatch(string fld, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", fld, got, want, $realtime);
    n_err++;
  endtask

  task automatic check_field(string fld, coord_t got, coord_t want);
    if (got !== want) report_mismatch(fld, longint'(got), longint'(want));
  endtask

  always @(posedge clk) begin
    tri_out_t w;
    if (rst_n && out_valid) begin
      if (subtri_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        w = subtri_q.pop_front();
        check_field("out_a_x", out_data.out_a_x, w.out_a_x);
        check_field("out_a_y", out_data.out_a_y, w.out_a_y);
        check_field("out_a_z", out_data.out_a_z, w.out_a_z);
        check_field("out_b_x", out_data.out_b_x, w.out_b_x);
        check_field("out_b_y", out_data.out_b_y, w.out_b_y);
        check_field("out_b_z", out_data.out_b_z, w.out_b_z);
        check_field("out_c_x", out_data.out_c_x, w.out_c_x);
        check_field("out_c_y", out_data.out_c_y, w.out_c_y);
        check_field("out_c_z", out_data.out_c_z, w.out_c_z);
        if (out_data.last !== w.last) begin
          report_mismatch("last", longint'(out_data.last), longint'(w.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired");
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic drain();
    while (subtri_q.size() != 0) @(negedge clk);
    repeat (FRAC + 45) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MODE:   cur_mode = val[MODE_W-1:0];
      CFG_SIZE_X: cur_size[0] = 64'(val);
      CFG_SIZE_Y: cur_size[1] = 64'(val);
      CFG_SIZE_Z: cur_size[2] = 64'(val);
    endcase
  endtask

  // caller sits at a falling edge; leaves start high, so a next transaction with no gap follows at once
  task automatic send_tri(tri_in_t t, bit typed, longint typed_ab [3]);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_data = t;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_subtris(t, typed, typed_ab);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      2:       return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_size();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'($urandom_range(0, 32'h40000));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic tri_in_t tri_of(longint v [9]);
    tri_in_t t;
    t = {coord_t'(v[0]), coord_t'(v[1]), coord_t'(v[2]), coord_t'(v[3]), coord_t'(v[4]),
         coord_t'(v[5]), coord_t'(v[6]), coord_t'(v[7]), coord_t'(v[8])};
    return t;
  endfunction

  task automatic add_row(logic [MODE_W-1:0] m, longint v [9], bit typed, longint ab [3]);
    dir_row_t r;
    r.mode = m;
    r.corners = tri_of(v);
    r.typed = typed;
    r.ab = ab;
    dir_rows.push_back(r);
  endtask

  initial begin
    longint none [3];
    longint mx, mn;
    tri_in_t t;
    none = '{0, 0, 0};
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    n_err = 0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MODE;
    cfg_data = '0;
    cur_mode = MODE_PLAIN;
    cur_size = '{64'(SIZE_RST), 64'(SIZE_RST), 64'(SIZE_RST)};
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    add_row(MODE_PLAIN, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0});
    add_row(MODE_PLAIN, '{mx, mx, mx, mx, mx, mx, mx, mx, mx}, 1, '{mx, mx, mx});
    add_row(MODE_PLAIN, '{mn, mn, mn, mn, mn, mn, mn, mn, mn}, 1, '{mn, mn, mn});
    add_row(MODE_PLAIN, '{mx, mx, mx, mn, mn, mn, 3, -3, 1}, 1, '{-1, -1, -1});
    add_row(MODE_PLAIN, '{-1, 1, -3, 0, 0, 0, 65536, -65536, 5}, 1, '{-1, 0, -2});
    add_row(MODE_ELLIPSOID, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0});
    add_row(MODE_ELLIPSOID, '{65536, 0, 0, 65536, 0, 0, 0, 65536, 0}, 1, '{65536, 0, 0});
    add_row(MODE_ELLIPSOID, '{1, -1, 0, -1, 1, 0, mx, mn, mx}, 0, none);
    add_row(MODE_ELLIPSOID, '{mx, mx, mx, mx, mx, mx, mn, mn, mn}, 0, none);
    add_row(MODE_ELLIPSOID, '{-5, 7, -9, 3, -2, 11, 100, 200, -300}, 0, none);
    add_row(MODE_ELLIPSE, '{0, 0, 70000, 0, 0, 90000, 4, 4, 4}, 1, '{0, 0, 80000});
    add_row(MODE_ELLIPSE, '{0, 65536, 9, 0, 65536, 9, mn, mx, mn}, 1, '{0, 32768, 9});
    add_row(MODE_ELLIPSE, '{mx, mn, 1, mx, mn, -1, -7, 3, 8}, 0, none);
    add_row(MODE_UNDEF, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0});
    add_row(MODE_UNDEF, '{10, 20, 30, 12, 22, 33, mx, mn, 0}, 1, '{11, 21, 31});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) begin
        start = 1'b0;
        drain();
        write_reg(CFG_MODE, CFG_W'(dir_rows[i].mode));
      end
      send_tri(dir_rows[i].corners, dir_rows[i].typed, dir_rows[i].ab);
    end

    for (int ph = 0; ph < 7; ph++) begin
      start = 1'b0;
      drain();
      write_reg(CFG_MODE, CFG_W'((ph < 4) ? ph[MODE_W-1:0]
                                          : MODE_W'($urandom_range(0, 3))));
      write_reg(CFG_SIZE_X, (ph == 1) ? '1 : (ph == 2) ? '0 : rand_size());
      write_reg(CFG_SIZE_Y, (ph == 1) ? '1 : (ph == 2) ? '0 : rand_size());
      write_reg(CFG_SIZE_Z, (ph == 1) ? '1 : (ph == 2) ? '0 : rand_size());
      for (int k = 0; k < N_RAND / 7; k++) begin
        t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        if (k == 25) begin
          start = 1'b0;
          while (subtri_q.size() != 0) @(negedge clk);
        end
        send_tri(t, 0, none);
      end
    end

    start = 1'b0;
    drain();
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### triangle_midpoint_subdivider.f
src/tmsd_pkg.sv
src/tmsd_norm.sv
src/triangle_midpoint_subdivider.sv
src/tmsd_chk.sv
dv/triangle_midpoint_subdivider_tb.sv
